[rtl/dgps_pkg.sv]
`timescale 1ns / 1ps

package dgps_pkg;

  localparam int PIX_W     = 8;
  localparam int DEPTH_W   = 17;
  localparam int NUM_GATES = 3;

  // gate order inside the per-gate arrays
  localparam int SLOT_NEAR = 0;
  localparam int SLOT_MID  = 1;
  localparam int SLOT_FAR  = 2;

  // apb register map, word index = paddr[4:2]
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_DEPTH_PRESENT = 3'd0,
    REG_NEAR_LO       = 3'd1,
    REG_NEAR_HI       = 3'd2,
    REG_MID_LO        = 3'd3,
    REG_MID_HI        = 3'd4,
    REG_FAR_LO        = 3'd5,
    REG_FAR_HI        = 3'd6
  } reg_idx_t;

  localparam logic [DEPTH_W-1:0] NEAR_LO_RST = 17'd2000;
  localparam logic [DEPTH_W-1:0] NEAR_HI_RST = 17'd18000;
  localparam logic [DEPTH_W-1:0] MID_LO_RST  = 17'd12000;
  localparam logic [DEPTH_W-1:0] MID_HI_RST  = 17'd42000;
  localparam logic [DEPTH_W-1:0] FAR_LO_RST  = 17'd32000;
  localparam logic [DEPTH_W-1:0] FAR_HI_RST  = 17'd85000;

  // distance in q10 and the long division that produces it
  localparam int E_W      = DEPTH_W + 1;
  localparam int NUM_W    = 34;
  localparam int DEN_W    = 23;
  localparam int Q_W      = 11;
  localparam int SPAN_MIN = 235;

  // gaussian weight table, q1.16, step 1/16
  localparam int W_W      = 17;
  localparam int TAB_N    = 20;
  localparam int TAB_IW   = 5;
  localparam int TAB_LAST = TAB_N - 1;
  localparam int DIFF_W   = 12;
  localparam int FRAC_W   = 6;

  localparam logic [W_W-1:0] GAUSS_TAB [0:TAB_N-1] = '{
    17'd65536, 17'd65408, 17'd65026, 17'd64394, 17'd63520,
    17'd62413, 17'd61086, 17'd59555, 17'd57835, 17'd55947,
    17'd53908, 17'd51742, 17'd49469, 17'd47112, 17'd44692,
    17'd42231, 17'd39750, 17'd37268, 17'd34806, 17'd32379
  };

  localparam int YW_W = PIX_W + W_W;

  typedef struct packed {
    logic [PIX_W-1:0]     y;
    logic [PIX_W-1:0]     b;
    logic [PIX_W-1:0]     g;
    logic [PIX_W-1:0]     r;
    logic                 bypass;
    logic [NUM_GATES-1:0] in_gate;
  } carry_t;

  // floor(a / 5) for a below 2560
  function automatic logic [PIX_W:0] div5(input logic [12:0] a);
    logic [28:0] p;
    p = 29'(a) * 29'(52429);
    return p[26:18];
  endfunction

  // round(0.85 * s + 0.15 * p), saturated
  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] s,
                                             input logic [PIX_W-1:0] p);
    logic [14:0] sum;
    logic [30:0] prod;
    logic [8:0]  q;
    sum  = 15'(s) * 15'(85) + 15'(p) * 15'(15) + 15'(50);
    prod = 31'(sum) * 31'(41944);
    q    = prod[30:22];
    return (q > 9'd255) ? 8'd255 : q[7:0];
  endfunction

endpackage

[rtl/depth_gated_pixel_slicer_top.sv]
`timescale 1ns / 1ps

// Depth-gated pixel slicer. Takes one pixel word a clock (blue, green, red, depth in mm and a
// depth valid flag) and returns one result word per pixel: 601 luma gated by near, mid and far
// range gates with a gaussian weight centred on each gate (gain 1.8, sigma = span / 2.35 but at
// least 100 mm), plus a range view that blends far, mid and near slices 0.85 / 0.15 with the
// original blue, green and red. A new word may enter every clock unless the output stalls, and
// most of the pipe is the eleven-stage restoring divider that turns the distance from the gate
// centre into table coordinates. When out_ready is low with a result
// waiting, the whole pipeline holds and in_ready drops. Registers sit on a small apb port at
// word addresses: 0 depth_present, 1/2 near low/high, 3/4 mid low/high, 5/6 far low/high (mm,
// 17 bits). With depth_present clear the slices carry luma and the view carries the pixel;
// an invalid depth counts as zero range. Change registers only while the pipeline is empty.
module depth_gated_pixel_slicer_top (
  input  logic                          clk,
  input  logic                          rst,
  // apb
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dgps_pkg::ADDR_W-1:0]   paddr,
  input  logic [dgps_pkg::DATA_W-1:0]   pwdata,
  output logic [dgps_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // pixel words in
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dgps_pkg::PIX_W-1:0]    pixel_blue,
  input  logic [dgps_pkg::PIX_W-1:0]    pixel_green,
  input  logic [dgps_pkg::PIX_W-1:0]    pixel_red,
  input  logic [dgps_pkg::DEPTH_W-1:0]  depth_mm,
  input  logic                          depth_valid,
  // result words out
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dgps_pkg::PIX_W-1:0]    near_value,
  output logic [dgps_pkg::PIX_W-1:0]    mid_value,
  output logic [dgps_pkg::PIX_W-1:0]    far_value,
  output logic [dgps_pkg::PIX_W-1:0]    view_blue,
  output logic [dgps_pkg::PIX_W-1:0]    view_green,
  output logic [dgps_pkg::PIX_W-1:0]    view_red
);

  import dgps_pkg::*;

  // pipeline positions after the front stage
  localparam int DIV_STAGES = Q_W;
  localparam int POS_DIV0   = 2;                 // first divider stage
  localparam int POS_W1     = POS_DIV0 + DIV_STAGES;
  localparam int POS_W2     = POS_W1 + 1;
  localparam int POS_MUL    = POS_W2 + 1;
  localparam int POS_SLICE  = POS_MUL + 1;
  localparam int PIPE_LEN   = POS_SLICE + 1;

  // ---------------------------------------------------------------- config registers
  logic                 depth_present;
  logic [DEPTH_W-1:0]   gate_lo [NUM_GATES];
  logic [DEPTH_W-1:0]   gate_hi [NUM_GATES];
  reg_idx_t             reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_present      <= 1'b0;
      gate_lo[SLOT_NEAR] <= NEAR_LO_RST;
      gate_hi[SLOT_NEAR] <= NEAR_HI_RST;
      gate_lo[SLOT_MID]  <= MID_LO_RST;
      gate_hi[SLOT_MID]  <= MID_HI_RST;
      gate_lo[SLOT_FAR]  <= FAR_LO_RST;
      gate_hi[SLOT_FAR]  <= FAR_HI_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEPTH_PRESENT: depth_present      <= pwdata[0];
        REG_NEAR_LO:       gate_lo[SLOT_NEAR] <= pwdata[DEPTH_W-1:0];
        REG_NEAR_HI:       gate_hi[SLOT_NEAR] <= pwdata[DEPTH_W-1:0];
        REG_MID_LO:        gate_lo[SLOT_MID]  <= pwdata[DEPTH_W-1:0];
        REG_MID_HI:        gate_hi[SLOT_MID]  <= pwdata[DEPTH_W-1:0];
        REG_FAR_LO:        gate_lo[SLOT_FAR]  <= pwdata[DEPTH_W-1:0];
        REG_FAR_HI:        gate_hi[SLOT_FAR]  <= pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DEPTH_PRESENT: prdata = DATA_W'(depth_present);
      REG_NEAR_LO:       prdata = DATA_W'(gate_lo[SLOT_NEAR]);
      REG_NEAR_HI:       prdata = DATA_W'(gate_hi[SLOT_NEAR]);
      REG_MID_LO:        prdata = DATA_W'(gate_lo[SLOT_MID]);
      REG_MID_HI:        prdata = DATA_W'(gate_hi[SLOT_MID]);
      REG_FAR_LO:        prdata = DATA_W'(gate_lo[SLOT_FAR]);
      REG_FAR_HI:        prdata = DATA_W'(gate_hi[SLOT_FAR]);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // one enable for the whole pipe: it moves unless a finished result is stuck
  logic adv;
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  // ---------------------------------------------------------------- front stage
  logic                 s1_valid;
  logic [PIX_W-1:0]     s1_b, s1_g, s1_r;
  logic [DEPTH_W-1:0]   s1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_b <= pixel_blue;
      s1_g <= pixel_green;
      s1_r <= pixel_red;
      s1_d <= depth_valid ? depth_mm : '0;   // invalid depth counts as zero
    end
  end

  // ---------------------------------------------------------------- luma and gate geometry
  logic [22:0]          luma_sum;
  logic [PIX_W-1:0]     luma;
  logic [E_W-1:0]       twice_d;
  logic [E_W-1:0]       lohi_sum [NUM_GATES];
  logic [E_W-1:0]       e_next   [NUM_GATES];
  logic [DEPTH_W-1:0]   span_next[NUM_GATES];
  logic [NUM_GATES-1:0] in_gate_next;

  assign luma_sum = 23'(s1_r) * 23'(4899) + 23'(s1_g) * 23'(9617)
                  + 23'(s1_b) * 23'(1868) + 23'(8192);
  assign luma     = luma_sum[21:14];
  assign twice_d  = {s1_d, 1'b0};

  always_comb begin
    for (int k = 0; k < NUM_GATES; k++) begin
      in_gate_next[k] = (s1_d >= gate_lo[k]) && (s1_d <= gate_hi[k]);
      span_next[k]    = gate_hi[k] - gate_lo[k];
      lohi_sum[k]     = E_W'(gate_lo[k]) + E_W'(gate_hi[k]);
      e_next[k]       = (twice_d > lohi_sum[k]) ? (twice_d - lohi_sum[k])
                                                : (lohi_sum[k] - twice_d);
    end
  end

  // ---------------------------------------------------------------- pipe registers
  logic                 pv     [PIPE_LEN];
  carry_t               pc     [PIPE_LEN];
  logic [E_W-1:0]       g_e    [NUM_GATES];
  logic [DEPTH_W-1:0]   g_span [NUM_GATES];
  logic [NUM_W-1:0]     rem    [DIV_STAGES+1][NUM_GATES];
  logic [DEN_W-1:0]     den    [DIV_STAGES+1][NUM_GATES];
  logic [Q_W-1:0]       quo    [DIV_STAGES+1][NUM_GATES];
  logic [W_W-1:0]       w_top  [NUM_GATES];
  logic [DIFF_W+FRAC_W-1:0] w_drop [NUM_GATES];
  logic [W_W-1:0]       weight [NUM_GATES];
  logic [YW_W-1:0]      yw     [NUM_GATES];
  logic [PIX_W-1:0]     slice  [NUM_GATES];

  carry_t               carry_next;

  always_comb begin
    carry_next         = '0;
    carry_next.y       = luma;
    carry_next.b       = s1_b;
    carry_next.g       = s1_g;
    carry_next.r       = s1_r;
    carry_next.bypass  = !depth_present;
    carry_next.in_gate = in_gate_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PIPE_LEN; p++) pv[p] <= 1'b0;
    end else if (adv) begin
      pv[0] <= s1_valid;
      for (int p = 1; p < PIPE_LEN; p++) pv[p] <= pv[p-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pc[0] <= carry_next;
      for (int p = 1; p < PIPE_LEN; p++) pc[p] <= pc[p-1];
      for (int k = 0; k < NUM_GATES; k++) begin
        g_e[k]    <= e_next[k];
        g_span[k] <= span_next[k];
      end
    end
  end

  // numerator and denominator: sigma floored at 100 mm for short spans
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_GATES; k++) begin
        quo[0][k] <= '0;
        if (g_span[k] >= DEPTH_W'(SPAN_MIN)) begin
          rem[0][k] <= (NUM_W'(g_e[k]) * NUM_W'(47)) << 10;
          den[0][k] <= (DEN_W'(g_span[k]) << 5) + (DEN_W'(g_span[k]) << 3);
        end else begin
          rem[0][k] <= NUM_W'(g_e[k]) << 10;
          den[0][k] <= DEN_W'(200);
        end
      end
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    localparam int BIT = DIV_STAGES - 1 - s;
    logic [NUM_W-1:0] dsh [NUM_GATES];

    always_comb begin
      for (int k = 0; k < NUM_GATES; k++) dsh[k] = NUM_W'(den[s][k]) << BIT;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < NUM_GATES; k++) begin
          den[s+1][k] <= den[s][k];
          if (rem[s][k] >= dsh[k]) begin
            rem[s+1][k] <= rem[s][k] - dsh[k];
            quo[s+1][k] <= quo[s][k] | (Q_W'(1) << BIT);
          end else begin
            rem[s+1][k] <= rem[s][k];
            quo[s+1][k] <= quo[s][k];
          end
        end
      end
    end
  end

  // table interpolation
  logic [TAB_IW-1:0] t_idx  [NUM_GATES];
  logic [FRAC_W-1:0] t_frac [NUM_GATES];
  logic [W_W-1:0]    t_diff [NUM_GATES];

  always_comb begin
    for (int k = 0; k < NUM_GATES; k++) begin
      t_idx[k]  = quo[DIV_STAGES][k][Q_W-1:FRAC_W];
      t_frac[k] = quo[DIV_STAGES][k][FRAC_W-1:0];
      if (t_idx[k] >= TAB_IW'(TAB_LAST)) begin
        t_diff[k] = '0;
      end else begin
        t_diff[k] = GAUSS_TAB[t_idx[k]] - GAUSS_TAB[t_idx[k] + TAB_IW'(1)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_GATES; k++) begin
        w_top[k]  <= (t_idx[k] >= TAB_IW'(TAB_LAST)) ? GAUSS_TAB[TAB_LAST]
                                                      : GAUSS_TAB[t_idx[k]];
        w_drop[k] <= (DIFF_W+FRAC_W)'(t_diff[k][DIFF_W-1:0]) * (DIFF_W+FRAC_W)'(t_frac[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_GATES; k++) begin
        weight[k] <= w_top[k] - W_W'(w_drop[k][DIFF_W+FRAC_W-1:FRAC_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_GATES; k++) begin
        yw[k] <= YW_W'(pc[POS_W2].y) * YW_W'(weight[k]);
      end
    end
  end

  // gain 1.8 = 9 / 5, then clamp; zero outside the gate
  logic [YW_W+3:0] yw9    [NUM_GATES];
  logic [PIX_W:0]  s_raw  [NUM_GATES];

  always_comb begin
    for (int k = 0; k < NUM_GATES; k++) begin
      yw9[k]   = {yw[k], 3'b000} + (YW_W+4)'(yw[k]);
      s_raw[k] = div5(yw9[k][YW_W+3:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_GATES; k++) begin
        if (!pc[POS_MUL].in_gate[k]) begin
          slice[k] <= '0;
        end else if (s_raw[k] > (PIX_W+1)'(255)) begin
          slice[k] <= 8'd255;
        end else begin
          slice[k] <= s_raw[k][PIX_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------- output register
  carry_t cs;
  assign cs = pc[POS_SLICE];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= pv[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cs.bypass) begin
        near_value <= cs.y;
        mid_value  <= cs.y;
        far_value  <= cs.y;
        view_blue  <= cs.b;
        view_green <= cs.g;
        view_red   <= cs.r;
      end else begin
        near_value <= slice[SLOT_NEAR];
        mid_value  <= slice[SLOT_MID];
        far_value  <= slice[SLOT_FAR];
        view_blue  <= blend(slice[SLOT_FAR], cs.b);
        view_green <= blend(slice[SLOT_MID], cs.g);
        view_red   <= blend(slice[SLOT_NEAR], cs.r);
      end
    end
  end

endmodule
